FILE: design/min_tracking_stack_core_macros.svh
// ----------------------------------------------------------------------------
// min_tracking_stack_core_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_CORE_MACROS_SVH
`define MIN_TRACKING_STACK_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MTS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("min stack check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MTS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("min stack check failed");

`endif

FILE: design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and codes of the min tracking stack
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POPW
  } state_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic pop_fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_read;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// sequencer: request intake, execute, pop refill and result handshake
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire mts_pkg::dp_status_t status_i,
  output mts_pkg::ctrl_cmd_t      cmd_o
);

  mts_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = mts_pkg::S_EXEC;
        end
      end
      mts_pkg::S_EXEC: begin
        if (out_free) begin
          state_d = status_i.pop_read ? mts_pkg::S_POPW : mts_pkg::S_IDLE;
        end
      end
      mts_pkg::S_POPW: begin
        state_d = mts_pkg::S_IDLE;
      end
      default: begin
        state_d = mts_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load_in = (state_q == mts_pkg::S_IDLE) && in_valid_i;
    cmd_o.exec    = (state_q == mts_pkg::S_EXEC) && out_free;
    cmd_o.pop_fin = (state_q == mts_pkg::S_POPW);
    in_stall_o    = (state_q != mts_pkg::S_IDLE);
    out_valid_d   = out_valid_q && out_stall_i;
    if ((cmd_o.exec && !status_i.pop_read) || cmd_o.pop_fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mts_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// value and minimum stores, cached top level, fill count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mts_datapath #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mts_pkg::ctrl_cmd_t cmd_i,
  output mts_pkg::dp_status_t     status_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] value_i,
  output logic signed [31:0]      item_value_o,
  output logic signed [31:0]      min_value_o,
  output logic [6:0]              count_o,
  output logic [1:0]              status_code_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    act_q;
  logic signed [31:0] val_q;
  logic signed [31:0] top_val_q, top_val_d, top_min_q, top_min_d;
  logic signed [31:0] pend_q, pend_d;
  logic signed [31:0] push_min;
  logic signed [31:0] o_item_q, o_item_d, o_min_q, o_min_d;
  logic [1:0]    o_st_q, o_st_d;
  logic [CW-1:0] cnt_sub2;
  logic [CW+6:0] cnt_ext;
  logic          empty, full, one_left, is_push, is_pop;

  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CW'(DEPTH));
  assign one_left = (cnt_q == CW'(1));
  assign is_push  = (act_q == mts_pkg::ACT_PUSH);
  assign is_pop   = (act_q == mts_pkg::ACT_POP);
  assign cnt_sub2 = cnt_q - CW'(2);
  assign rd_addr  = cnt_sub2[AW-1:0];
  assign push_min = (empty || (val_q < top_min_q)) ? val_q : top_min_q;

  assign status_o.pop_read = is_pop && !empty && !one_left;
  assign rd_en = cmd_i.exec && status_o.pop_read;
  assign wr_en = cmd_i.exec && is_push && !full;

  always_comb begin
    cnt_d     = cnt_q;
    top_val_d = top_val_q;
    top_min_d = top_min_q;
    pend_d    = pend_q;
    o_item_d  = o_item_q;
    o_min_d   = o_min_q;
    o_st_d    = o_st_q;
    if (cmd_i.exec) begin
      o_st_d   = mts_pkg::ST_OK;
      o_item_d = empty ? '0 : top_val_q;
      o_min_d  = empty ? '0 : top_min_q;
      if (is_push) begin
        if (full) begin
          o_st_d = mts_pkg::ST_OVERFLOW;
        end else begin
          cnt_d     = cnt_q + CW'(1);
          top_val_d = val_q;
          top_min_d = push_min;
          o_item_d  = val_q;
          o_min_d   = push_min;
        end
      end else if (is_pop) begin
        if (empty) begin
          o_st_d = mts_pkg::ST_UNDERFLOW;
        end else begin
          cnt_d    = cnt_q - CW'(1);
          pend_d   = top_val_q;
          o_item_d = top_val_q;
          o_min_d  = '0;
        end
      end
    end else if (cmd_i.pop_fin) begin
      top_val_d = rd_q[63:32];
      top_min_d = rd_q[31:0];
      o_item_d  = pend_q;
      o_min_d   = rd_q[31:0];
      o_st_d    = mts_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= {val_q, push_min};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q <= action_i;
      val_q <= value_i;
    end
    top_val_q <= top_val_d;
    top_min_q <= top_min_d;
    pend_q    <= pend_d;
    o_item_q  <= o_item_d;
    o_min_q   <= o_min_d;
    o_st_q    <= o_st_d;
  end

  assign cnt_ext       = {7'd0, cnt_q};
  assign count_o       = cnt_ext[6:0];
  assign item_value_o  = o_item_q;
  assign min_value_o   = o_min_q;
  assign status_code_o = o_st_q;

endmodule

`default_nettype wire

FILE: design/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// fixed-depth signed stack that reports its minimum with every request
// ----------------------------------------------------------------------------
// A request is taken into an input register, executed when the output
// register is free and its result placed there, so a new request is taken
// while a result waits. Push, query, overflow and underflow finish in the
// execute state; a pop that leaves the stack non-empty then passes a further
// state, the registered read of the new top level from the single-port
// store. The top level's value and minimum are cached in flops; the stores
// hold no reset and need no clearing pass. The count output shows the fill
// level in seven bits.
`default_nettype none

module min_tracking_stack_core #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      item_value_o,
  output logic signed [31:0]      min_value_o,
  output logic [6:0]              count_o,
  output logic [1:0]              status_o
);

  mts_pkg::ctrl_cmd_t  cmd;
  mts_pkg::dp_status_t dp_status;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  mts_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .action_i      (action_i),
    .value_i       (value_i),
    .item_value_o  (item_value_o),
    .min_value_o   (min_value_o),
    .count_o       (count_o),
    .status_code_o (status_o)
  );

endmodule

`default_nettype wire

FILE: design/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// port-level checks of the min tracking stack, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_tracking_stack_core_macros.svh"

module mts_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] item_value_o,
  input wire logic signed [31:0] min_value_o,
  input wire logic [6:0]         count_o,
  input wire logic [1:0]         status_o
);

  `MTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `MTS_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(item_value_o) && $stable(min_value_o) && $stable(count_o) && $stable(status_o))
  `MTS_ASSERT_NOW(a_underflow_empty, out_valid_o && (status_o == mts_pkg::ST_UNDERFLOW), (count_o == 7'd0) && (item_value_o == 32'sd0) && (min_value_o == 32'sd0))
  `MTS_ASSERT_NOW(a_overflow_min, out_valid_o && (status_o == mts_pkg::ST_OVERFLOW), min_value_o <= item_value_o)

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .item_value_o (item_value_o),
  .min_value_o  (min_value_o),
  .count_o      (count_o),
  .status_o     (status_o)
);

`default_nettype wire

FILE: test/min_tracking_stack_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core_tb
// self-checking bench for the min tracking stack core
// ----------------------------------------------------------------------------
// A driver process feeds requests from a queue that the stimulus block fills:
// a short directed run over the empty, tie and extreme cases, a fill past the
// top and a drain past the bottom, then random bursts that lean toward
// pushing, popping or noise. Every accepted request is run through a shadow
// stack and the expected result is queued. The monitor compares each result
// field by field, with random receiver stalls and one long hold-off.

module min_tracking_stack_core_tb;

  localparam int STACK_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1350;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] value;
    int                 gap;
  } stack_request_t;

  typedef struct {
    logic signed [31:0] item_val;
    logic signed [31:0] min_val;
    logic [6:0]         count;
    logic [1:0]         status;
  } stack_result_t;

  typedef enum int {
    MIX_PUSH,
    MIX_POP,
    MIX_EVEN,
    MIX_NOISE,
    MIX_FILL,
    MIX_DRAIN
  } mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] action_i = ACT_QUERY;
  logic signed [31:0] value_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [31:0] item_value_o;
  logic signed [31:0] min_value_o;
  logic [6:0] count_o;
  logic [1:0] status_o;

  stack_request_t request_queue[$];
  stack_result_t expected_results[$];

  logic signed [31:0] shadow_values[STACK_DEPTH];
  logic signed [31:0] shadow_mins[STACK_DEPTH];
  int shadow_fill = 0;

  int err_count = 0;
  int results_seen = 0;
  int stall_left = 0;
  logic hold_off = 1'b0;

  min_tracking_stack_core #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_value_o(item_value_o),
    .min_value_o (min_value_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void stack_apply(input logic [1:0] act, input logic signed [31:0] val);
    stack_result_t res;
    logic signed [31:0] run_min;
    bit popped;
    res.item_val = '0;
    res.min_val = '0;
    res.status = mts_pkg::ST_OK;
    popped = 1'b0;
    if (act == mts_pkg::ACT_PUSH) begin
      if (shadow_fill >= STACK_DEPTH) begin
        res.status = mts_pkg::ST_OVERFLOW;
      end else begin
        run_min = val;
        if (shadow_fill > 0 && shadow_mins[shadow_fill-1] < val) begin
          run_min = shadow_mins[shadow_fill-1];
        end
        shadow_values[shadow_fill] = val;
        shadow_mins[shadow_fill] = run_min;
        shadow_fill++;
      end
    end else if (act == mts_pkg::ACT_POP) begin
      if (shadow_fill == 0) begin
        res.status = mts_pkg::ST_UNDERFLOW;
      end else begin
        shadow_fill--;
        res.item_val = shadow_values[shadow_fill];
        popped = 1'b1;
      end
    end
    if (shadow_fill > 0) begin
      if (!popped) res.item_val = shadow_values[shadow_fill-1];
      res.min_val = shadow_mins[shadow_fill-1];
    end
    res.count = 7'(shadow_fill);
    expected_results.push_back(res);
  endfunction

  function automatic void add_request(input logic [1:0] act, input logic signed [31:0] val,
                                      input int gap);
    stack_request_t req;
    req.action = act;
    req.value = val;
    req.gap = gap;
    request_queue.push_back(req);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      5, 6:    return $signed($urandom_range(0, 16)) - 32'sd8;
      7:       return VAL_MAX;
      8:       return VAL_MIN;
      9:       return VAL_MIN | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_action(input mix_e mix);
    int r;
    logic [1:0] lead;
    logic [1:0] other;
    r = $urandom_range(0, 99);
    lead = (mix == MIX_POP) ? mts_pkg::ACT_POP : mts_pkg::ACT_PUSH;
    other = (mix == MIX_POP) ? mts_pkg::ACT_PUSH : mts_pkg::ACT_POP;
    case (mix)
      MIX_FILL:  return mts_pkg::ACT_PUSH;
      MIX_DRAIN: return mts_pkg::ACT_POP;
      MIX_NOISE: return 2'($urandom_range(0, 3));
      MIX_EVEN: begin
        if (r < 45) return mts_pkg::ACT_PUSH;
        if (r < 90) return mts_pkg::ACT_POP;
      end
      default: begin
        if (r < 75) return lead;
        if (r < 90) return other;
      end
    endcase
    return (r < 95) ? ACT_QUERY : ACT_SPARE;
  endfunction

  // driver
  always @(posedge clk_i) begin
    stack_request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) stack_apply(action_i, value_i);
      if (!(in_valid_i && in_stall_o)) begin
        if (request_queue.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (request_queue[0].gap > 0) begin
          request_queue[0].gap = request_queue[0].gap - 1;
          in_valid_i <= 1'b0;
        end else begin
          req = request_queue.pop_front();
          action_i <= req.action;
          value_i <= req.value;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stack_result_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (err_count < 10) begin
            $display("unexpected result: item %0d min %0d count %0d status %0d",
                     item_value_o, min_value_o, count_o, status_o);
          end
          err_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (item_value_o !== exp_res.item_val || min_value_o !== exp_res.min_val ||
              count_o !== exp_res.count || status_o !== exp_res.status) begin
            if (err_count < 10) begin
              $display("mismatch at result %0d: expected item %0d min %0d count %0d status %0d",
                       results_seen, exp_res.item_val, exp_res.min_val, exp_res.count,
                       exp_res.status);
              $display("  actual item %0d min %0d count %0d status %0d",
                       item_value_o, min_value_o, count_o, status_o);
            end
            err_count++;
          end
        end
        results_seen++;
        stall_left = ((results_seen % 256) < 64) ? 0 : $urandom_range(0, 4);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= hold_off || (stall_left > 0);
    end
  end

  // long receiver hold-off so the core fills and stalls its input
  initial begin
    while (results_seen < 300) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[min_tracking_stack_core] ERROR");
    $finish;
  end

  initial begin
    mix_e mix;
    int burst_len;
    int sel;
    bit calm;

    // empty stack, extremes, ties and the spare action code
    add_request(ACT_QUERY, 32'sd0, 0);
    add_request(ACT_SPARE, VAL_MAX, 1);
    add_request(mts_pkg::ACT_POP, VAL_MIN, 0);
    add_request(mts_pkg::ACT_POP, 32'sd0, 2);
    add_request(mts_pkg::ACT_PUSH, VAL_MAX, 0);
    add_request(ACT_QUERY, 32'sd0, 0);
    add_request(mts_pkg::ACT_PUSH, VAL_MIN, 3);
    add_request(mts_pkg::ACT_PUSH, VAL_MAX, 0);
    add_request(mts_pkg::ACT_PUSH, VAL_MIN, 0);
    add_request(mts_pkg::ACT_PUSH, -32'sd1, 1);
    add_request(mts_pkg::ACT_PUSH, 32'sd0, 0);
    add_request(ACT_SPARE, 32'sd0, 0);
    add_request(mts_pkg::ACT_POP, 32'sd0, 4);
    add_request(mts_pkg::ACT_POP, 32'sd0, 0);
    add_request(mts_pkg::ACT_POP, 32'sd0, 0);
    add_request(ACT_QUERY, 32'sd0, 1);
    add_request(mts_pkg::ACT_POP, 32'sd0, 0);
    add_request(mts_pkg::ACT_POP, 32'sd0, 0);
    add_request(mts_pkg::ACT_POP, 32'sd0, 2);
    add_request(mts_pkg::ACT_POP, 32'sd0, 0);
    add_request(mts_pkg::ACT_PUSH, 32'sd0, 0);
    add_request(mts_pkg::ACT_POP, 32'sd0, 0);

    // fill past the top, then drain past the bottom
    repeat (STACK_DEPTH + 3) add_request(mts_pkg::ACT_PUSH, pick_value(), $urandom_range(0, 4));
    add_request(ACT_QUERY, 32'sd0, 0);
    add_request(ACT_SPARE, 32'sd0, 0);
    repeat (STACK_DEPTH + 3) add_request(mts_pkg::ACT_POP, pick_value(), $urandom_range(0, 4));

    while (request_queue.size() < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 6) mix = MIX_PUSH;
      else if (sel < 12) mix = MIX_POP;
      else if (sel < 16) mix = MIX_EVEN;
      else if (sel < 18) mix = MIX_NOISE;
      else if (sel == 18) mix = MIX_FILL;
      else mix = MIX_DRAIN;
      burst_len = (mix == MIX_FILL || mix == MIX_DRAIN) ? STACK_DEPTH + 6
                                                        : $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        add_request(pick_action(mix), pick_value(), calm ? 0 : $urandom_range(0, 4));
      end
    end

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("[min_tracking_stack_core] OK");
    end else begin
      $display("[min_tracking_stack_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: min_tracking_stack_core.f
+incdir+design
design/mts_pkg.sv
design/mts_ctrl.sv
design/mts_datapath.sv
design/min_tracking_stack_core.sv
design/mts_checker.sv
test/min_tracking_stack_core_tb.sv
